### design/mexp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation core.
package mexp_pkg;

	// Width of the item and register ports.
	localparam int DATA_BITS = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQ_WAIT,
		ST_MUL,
		ST_MUL_WAIT
	} mexp_state_t;

endpackage

### design/mexp_mulmod.sv
`timescale 1ns / 1ps
// Shared bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle.
module mexp_mulmod #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS:0]   m_ext,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);

	localparam int CntBits = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	logic                 busy_q;
	logic                 done_q;
	logic [CntBits-1:0]   cnt_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] r_q;

	logic [WORD_BITS+1:0] add_term;
	logic [WORD_BITS+1:0] sum;
	logic [WORD_BITS+1:0] m1;
	logic [WORD_BITS+1:0] m2;
	logic [WORD_BITS-1:0] r_next;

	// r < m and a < m keep 2r + a below 3m: at most two subtractions of m.
	always_comb begin
		add_term = b_q[WORD_BITS-1] ? {2'b00, a_q} : '0;
		sum      = {1'b0, r_q, 1'b0} + add_term;
		m1       = {1'b0, m_ext};
		m2       = {m_ext, 1'b0};
		if (sum >= m2) begin
			r_next = WORD_BITS'(sum - m2);
		end else if (sum >= m1) begin
			r_next = WORD_BITS'(sum - m1);
		end else begin
			r_next = sum[WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(WORD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = r_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

	a_operand_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ({1'b0, a} < m_ext))
		else $error("multiplicand not reduced");

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q || done_q) |-> ({1'b0, r_q} < m_ext))
		else $error("partial remainder out of range");

endmodule

### design/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// Top level: exponent-bit sequencer around the shared modular multiplier.
//
// Computes base_value ** exponent_value mod modulus, scanning the exponent from its top
// bit down with one squaring per bit and one extra multiply per set bit, all done on a
// single bit-serial modular multiplier. An exponent of zero answers 1 right away.
// The result appears for one cycle with done high and must be taken then, since there
// is no back-pressure. A modulus of zero means 2**WORD_BITS.
// The modulus register resets to 1 and is written only while busy is low.
module modular_exponentiation_core #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mexp_pkg::DATA_BITS-1:0] base_value,
	input  logic [mexp_pkg::DATA_BITS-1:0] exponent_value,
	output logic                          done,
	output logic [mexp_pkg::DATA_BITS-1:0] power_result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mexp_pkg::DATA_BITS-1:0] cfg_data
);

	import mexp_pkg::*;

	localparam int CntBits = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	mexp_state_t state_q;
	mexp_state_t state_next;

	logic [DATA_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [CntBits-1:0]   bit_cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic                 done_q;
	logic [DATA_BITS-1:0] power_result_q;

	logic [WORD_BITS-1:0] m_cut;
	logic [WORD_BITS:0]   m_ext;
	logic [WORD_BITS-1:0] base_cut;
	logic [WORD_BITS-1:0] exp_cut;
	logic                 accept;
	logic                 zero_item;
	logic                 last_bit;

	logic                 mul_start;
	logic [WORD_BITS-1:0] mul_b;
	logic                 mul_busy;
	logic                 mul_done;
	logic [WORD_BITS-1:0] mul_res;
	logic                 acc_load;
	logic                 step_next;
	logic                 finish;

	assign m_cut     = modulus_q[WORD_BITS-1:0];
	assign m_ext     = (m_cut == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, m_cut};
	assign base_cut  = base_value[WORD_BITS-1:0];
	assign exp_cut   = exponent_value[WORD_BITS-1:0];
	assign accept    = start && (state_q == ST_IDLE);
	assign zero_item = accept && (exp_cut == '0);
	assign last_bit  = (bit_cnt_q == '0);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (exp_cut != '0)) state_next = ST_SQ;
			end
			ST_SQ: begin
				state_next = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (mul_done) begin
					if (y_q[WORD_BITS-1]) state_next = ST_MUL;
					else if (last_bit)    state_next = ST_IDLE;
					else                  state_next = ST_SQ;
				end
			end
			ST_MUL: begin
				state_next = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (mul_done) state_next = last_bit ? ST_IDLE : ST_SQ;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_start = 1'b0;
		mul_b     = acc_q;
		acc_load  = 1'b0;
		step_next = 1'b0;
		finish    = 1'b0;
		case (state_q)
			ST_SQ: begin
				mul_start = 1'b1;
			end
			ST_SQ_WAIT: begin
				acc_load = mul_done;
				if (mul_done && !y_q[WORD_BITS-1]) begin
					finish    = last_bit;
					step_next = !last_bit;
				end
			end
			ST_MUL: begin
				mul_start = 1'b1;
				mul_b     = x_q;
			end
			ST_MUL_WAIT: begin
				mul_b     = x_q;
				acc_load  = mul_done;
				finish    = mul_done && last_bit;
				step_next = mul_done && !last_bit;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      (mul_b),
		.m_ext  (m_ext),
		.busy   (mul_busy),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			modulus_q <= DATA_BITS'(1);
		end else begin
			state_q <= state_next;
			done_q  <= finish || zero_item;
			if (cfg_valid && cfg_ready) modulus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= base_cut;
			y_q       <= exp_cut;
			bit_cnt_q <= CntBits'(WORD_BITS - 1);
			// 1 mod m, so the accumulator is always reduced
			acc_q     <= (m_ext == (WORD_BITS + 1)'(1)) ? '0 : WORD_BITS'(1);
		end else begin
			if (acc_load) acc_q <= mul_res;
			if (step_next) begin
				y_q       <= {y_q[WORD_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
		end
		if (zero_item) begin
			power_result_q <= DATA_BITS'(1);
		end else if (finish) begin
			power_result_q <= DATA_BITS'(mul_res);
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cfg_ready    = (state_q == ST_IDLE);
	assign done         = done_q;
	assign power_result = power_result_q;

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier issued while busy");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, acc_q} < m_ext))
		else $error("accumulator not reduced");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((power_result_q == DATA_BITS'(1))
			|| ({1'b0, power_result_q} < (DATA_BITS + 1)'(m_ext))))
		else $error("result out of range");

	a_wait_has_op: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SQ_WAIT) || (state_q == ST_MUL_WAIT)) |-> (mul_busy || mul_done))
		else $error("waiting with no multiply in flight");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for modular_exponentiation_core: queued stimulus, result scoreboard.
module tb_top;
	import mexp_pkg::*;

	typedef struct {
		logic [DATA_BITS-1:0] base;
		logic [DATA_BITS-1:0] expo;
	} power_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [DATA_BITS-1:0] base_value = '0;
	logic [DATA_BITS-1:0] exponent_value = '0;
	logic                 done;
	logic [DATA_BITS-1:0] power_result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [DATA_BITS-1:0] cfg_data = '0;

	power_item_t          pending_items[$];
	logic [DATA_BITS-1:0] expected_powers[$];
	logic [DATA_BITS-1:0] modulus_now = 1;
	int                   mismatch_count = 0;
	int                   burst_left = 1;
	int                   gap_left = 0;

	power_item_t          corner_items[6];
	logic [DATA_BITS-1:0] corner_moduli[3];
	logic [DATA_BITS-1:0] sweep_moduli[8];

	modular_exponentiation_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.done          (done),
		.power_result  (power_result),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] reduce_mod(input logic [63:0] v,
			input logic [DATA_BITS-1:0] m);
		if (m == 0)
			return {32'd0, v[DATA_BITS-1:0]};
		return v % {32'd0, m};
	endfunction

	// Square-and-multiply from the top exponent bit; a zero modulus wraps at the word size.
	function automatic logic [DATA_BITS-1:0] mod_power(input logic [DATA_BITS-1:0] b,
			input logic [DATA_BITS-1:0] e, input logic [DATA_BITS-1:0] m);
		logic [63:0] acc;
		acc = 64'd1;
		if (e != 0) begin
			for (int i = DATA_BITS - 1; i >= 0; i--) begin
				acc = reduce_mod(acc * acc, m);
				if (e[i])
					acc = reduce_mod(acc * b, m);
			end
		end
		return acc[DATA_BITS-1:0];
	endfunction

	function automatic logic [DATA_BITS-1:0] pick_base(input logic [DATA_BITS-1:0] m);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return '1;
			3: return m - 1;
			4: return m;
			5: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_BITS-1:0] pick_exponent();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return '1;
			2, 3: return $urandom_range(1, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 0;
		if (r < 8)
			return $urandom_range(1, 4);
		return $urandom_range(5, 30);
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
			input logic [DATA_BITS-1:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_powers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [DATA_BITS-1:0] m);
		wait_idle();
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		modulus_now = m;
	endtask

	// Driver: start stays up until busy is low at an edge; gaps only count down while idle.
	always @(posedge clk) begin
		if (start) begin
			if (!busy) begin
				expected_powers.push_back(mod_power(base_value, exponent_value, modulus_now));
				void'(pending_items.pop_front());
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 8);
					gap_left = pick_gap();
				end
				if (gap_left == 0 && pending_items.size() != 0) begin
					start <= 1'b1;
					base_value <= pending_items[0].base;
					exponent_value <= pending_items[0].expo;
				end else begin
					start <= 1'b0;
				end
			end
		end else if (gap_left != 0) begin
			if (!busy)
				gap_left--;
		end else if (pending_items.size() != 0) begin
			start <= 1'b1;
			base_value <= pending_items[0].base;
			exponent_value <= pending_items[0].expo;
		end
	end

	// Monitor: done is a one-cycle strobe with no back-pressure.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_powers.size() == 0)
				report_mismatch("unexpected power_result", power_result, '0);
			else if (power_result !== expected_powers[0])
				report_mismatch("power_result", power_result, expected_powers.pop_front());
			else
				void'(expected_powers.pop_front());
		end
	end

	initial begin
		corner_items = '{
			'{base: 32'h0000_0000, expo: 32'h0000_0000},
			'{base: 32'hFFFF_FFFF, expo: 32'hFFFF_FFFF},
			'{base: 32'h0000_0000, expo: 32'hFFFF_FFFF},
			'{base: 32'hFFFF_FFFF, expo: 32'h0000_0000},
			'{base: 32'hFFFF_FFFF, expo: 32'h0000_0001},
			'{base: 32'h0000_0007, expo: 32'h8000_0001}
		};
		corner_moduli = '{32'h0000_0000, 32'hFFFF_FFFB, 32'h0000_0002};
		sweep_moduli = '{32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
			32'h0000_0003, 32'h0001_0001, 32'h8000_0000, 32'h0000_0000};
		sweep_moduli[7] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners first under the reset modulus of one, then under a few written ones
		foreach (corner_items[i])
			pending_items.push_back(corner_items[i]);
		foreach (corner_moduli[k]) begin
			write_modulus(corner_moduli[k]);
			foreach (corner_items[i])
				pending_items.push_back(corner_items[i]);
		end

		foreach (sweep_moduli[k]) begin
			write_modulus(k == 5 ? 32'($urandom_range(4, 1000)) : sweep_moduli[k]);
			repeat (32)
				pending_items.push_back(power_item_t'{base: pick_base(modulus_now),
					expo: pick_exponent()});
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
